>>> rtl/magma_block_cipher_macros.svh
// Assertion macros used by the Magma block cipher controller.
`ifndef MAGMA_BLOCK_CIPHER_MACROS_SVH
`define MAGMA_BLOCK_CIPHER_MACROS_SVH

// Same-cycle implication, inactive while reset is asserted.
`define MGBC_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed: lhs |-> rhs");

// Next-cycle implication, inactive while reset is asserted.
`define MGBC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed: lhs |=> rhs");

`endif

>>> rtl/mgbc_pkg.sv
// Types, constants and the round function of the Magma block cipher.
package mgbc_pkg;

  localparam int unsigned HALF_W     = 32;
  localparam int unsigned BLOCK_W    = 2 * HALF_W;
  localparam int unsigned KEY_WORDS  = 8;
  localparam int unsigned KEY_IDX_W  = $clog2(KEY_WORDS);
  localparam int unsigned ROUNDS     = 32;
  localparam int unsigned RND_W      = $clog2(ROUNDS);
  localparam int unsigned ROT_AMT    = 11;
  localparam int unsigned NIBBLES    = HALF_W / 4;

  typedef logic [HALF_W-1:0]    half_t;
  typedef logic [BLOCK_W-1:0]   block_t;
  typedef logic [KEY_IDX_W-1:0] key_idx_t;
  typedef logic [RND_W-1:0]     rnd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;      // take a new input block into the half registers
    logic     round_en;  // run one Feistel round
    logic     out_load;  // move the finished block into the output register
    key_idx_t key_sel;   // round key word for this round
  } mgbc_cmd_t;

  // Fixed Magma substitution table, row 0 serves the most significant nibble.
  localparam logic [3:0] SBOX [NIBBLES][16] = '{
    '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
      4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2},
    '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
      4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
    '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
      4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
    '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
      4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
    '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
      4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
    '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
      4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
    '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
      4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
    '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
      4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1}
  };

  // Round function: add key mod 2^32, substitute nibbles, rotate left.
  function automatic half_t mgbc_round_f(input half_t half, input half_t key);
    half_t sum;
    half_t sub;
    sum = half + key;
    for (int n = 0; n < NIBBLES; n++) begin
      sub[HALF_W-1-4*n -: 4] = SBOX[n][sum[HALF_W-1-4*n -: 4]];
    end
    return {sub[HALF_W-1-ROT_AMT:0], sub[HALF_W-1:HALF_W-ROT_AMT]};
  endfunction

endpackage

>>> rtl/magma_block_cipher.sv
// An accepted beat runs its 32 rounds in the half registers, then moves into the output register that drives out_tdata.
// The single round unit runs one Feistel round a cycle; a new block is taken only once the last one is finished.
// The next beat is taken in the cycle the finished block moves into the output register.
// Reset: rst_n synchronous active low; clears control state and all key words to zero.
// The user must write key words through the cfg port only while the block is idle; the block does not enforce this.
// Top level of the Magma (GOST 28147-89) block cipher.
module magma_block_cipher
  import mgbc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration: register index 0..7 selects key_word_0..key_word_7
  input  logic               cfg_we,
  input  logic [KEY_IDX_W-1:0] cfg_index,
  input  logic [HALF_W-1:0]  cfg_wdata,
  // input beats
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [BLOCK_W-1:0] in_tdata,   // [63:0] block_in
  input  logic               in_tuser,   // [0] req_type (0 encrypt, 1 decrypt)
  // result beats
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [BLOCK_W-1:0] out_tdata   // [63:0] block_out
);

  mgbc_cmd_t cmd;

  // Sequencer: counts rounds, picks key words, owns both handshakes.
  mgbc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_dec     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Round hardware: key store, half registers and output holding register.
  mgbc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .blk_in    (in_tdata),
    .blk_out   (out_tdata)
  );

endmodule

>>> rtl/mgbc_dp.sv
// Datapath: key words, Feistel half registers and the output register.
module mgbc_dp
  import mgbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  key_idx_t  cfg_index,
  input  half_t     cfg_wdata,
  input  mgbc_cmd_t cmd,
  input  block_t    blk_in,
  output block_t    blk_out
);

  half_t  key_r [KEY_WORDS];
  half_t  hi_r, hi_nxt;
  half_t  lo_r, lo_nxt;
  block_t out_r, out_nxt;
  half_t  f_val;

  // Key words reset to zero; the user must write them only while the block is idle, which is not enforced here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_WORDS; i++) key_r[i] <= '0;
    end else if (cfg_we) begin
      key_r[cfg_index] <= cfg_wdata;
    end
  end

  assign f_val = mgbc_round_f(lo_r, key_r[cmd.key_sel]);

  always_comb begin
    hi_nxt  = hi_r;
    lo_nxt  = lo_r;
    out_nxt = out_r;
    if (cmd.load) begin
      hi_nxt = blk_in[BLOCK_W-1:HALF_W];
      lo_nxt = blk_in[HALF_W-1:0];
    end else if (cmd.round_en) begin
      hi_nxt = lo_r;
      lo_nxt = hi_r ^ f_val;
    end
    // Undo the final swap on the way out.
    if (cmd.out_load) out_nxt = {lo_r, hi_r};
  end

  always_ff @(posedge clk) begin
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    out_r <= out_nxt;
  end

  assign blk_out = out_r;

endmodule

>>> rtl/mgbc_ctrl.sv
// Controller: round sequencer, key schedule and handshake control.
`include "magma_block_cipher_macros.svh"

module mgbc_ctrl
  import mgbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  logic      in_dec,
  output logic      out_tvalid,
  input  logic      out_tready,
  output mgbc_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam rnd_t RND_LAST = RND_W'(ROUNDS - 1);

  logic [1:0] state_r, state_nxt;
  rnd_t       rnd_r, rnd_nxt;
  logic       dec_r, dec_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       in_acc;
  logic       late;

  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) || ((state_r == S_DONE) && out_free);
  assign in_acc = in_tvalid && in_tready;

  // Key order: encrypt runs 0..7 three times then 7..0; decrypt 0..7 once then 7..0 three times.
  assign late = dec_r ? (rnd_r[RND_W-1:3] != '0) : (rnd_r[RND_W-1:3] == '1);

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    dec_nxt       = dec_r;
    cmd.load      = in_acc;
    cmd.round_en  = 1'b0;
    cmd.out_load  = 1'b0;
    cmd.key_sel   = late ? ~rnd_r[2:0] : rnd_r[2:0];
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_RUN;
      end
      S_RUN: begin
        cmd.round_en = 1'b1;
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == RND_LAST) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = in_acc ? S_RUN : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (in_acc) begin
      rnd_nxt = '0;
      dec_nxt = in_dec;
    end
  end

  always_comb begin
    if (cmd.out_load)     out_valid_nxt = 1'b1;
    else if (out_tready)  out_valid_nxt = 1'b0;
    else                  out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rnd_r       <= '0;
      dec_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      dec_r       <= dec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `MGBC_ASSERT_NEXT(a_acc_starts, clk, rst_n, in_acc, (state_r == S_RUN) && (rnd_r == '0))
  `MGBC_ASSERT_NEXT(a_last_done, clk, rst_n, (state_r == S_RUN) && (rnd_r == RND_LAST), state_r == S_DONE)
  `MGBC_ASSERT_IMPLY(a_run_busy, clk, rst_n, state_r == S_RUN, !in_tready)
  `MGBC_ASSERT_NEXT(a_load_valid, clk, rst_n, cmd.out_load, out_valid_r)

endmodule

>>> tb/sv/tb_magma_block_cipher.sv
// Self-checking testbench of the Magma block cipher: directed table, then random beats.
module tb_magma_block_cipher;
  import mgbc_pkg::*;

  // Random beats over all segments; each segment gets its own key set and idle mode.
  localparam int unsigned RANDOM_BEATS = 1600;
  localparam int unsigned SEGMENTS     = 8;
  // Settling time after the drain, before the verdict.
  localparam int unsigned SETTLE_CYCLES = 48;
  // Watchdog limit in time units, far past the slowest correct run.
  localparam int unsigned WATCHDOG_TU   = 8000000;

  typedef enum logic { OP_ENCRYPT = 1'b0, OP_DECRYPT = 1'b1 } op_e;
  typedef enum logic [1:0] {
    KEYS_RESET,     // all zero, as after reset
    KEYS_STANDARD,  // key of the published Magma test vector
    KEYS_ONES,      // every key bit set
    KEYS_RANDOM     // random words mixed with the extremes
  } key_set_e;

  // Published test key, round key words K1..K8.
  localparam half_t STANDARD_KEY [KEY_WORDS] = '{
    32'hffeeddcc, 32'hbbaa9988, 32'h77665544, 32'h33221100,
    32'hf0f1f2f3, 32'hf4f5f6f7, 32'hf8f9fafb, 32'hfcfdfeff
  };

  // Substitution rows; row 0 takes the most significant nibble.
  localparam logic [3:0] SUBST [8][16] = '{
    '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
      4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2},
    '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
      4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
    '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
      4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
    '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
      4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
    '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
      4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
    '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
      4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
    '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
      4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
    '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
      4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1}
  };

  // Directed stimulus. Rows with typed set carry a known answer; the rest go to the predictor.
  typedef struct packed {
    key_set_e keys;
    op_e      op;
    block_t   blk;
    logic     typed;
    block_t   want;
  } directed_row_t;

  localparam int unsigned DIRECTED_ROWS = 17;
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    // key words as left by reset
    '{KEYS_RESET,    OP_ENCRYPT, 64'h0000000000000000, 1'b0, 64'h0},
    '{KEYS_RESET,    OP_DECRYPT, 64'h0000000000000000, 1'b0, 64'h0},
    '{KEYS_RESET,    OP_ENCRYPT, 64'hffffffffffffffff, 1'b0, 64'h0},
    '{KEYS_RESET,    OP_DECRYPT, 64'hffffffffffffffff, 1'b0, 64'h0},
    '{KEYS_RESET,    OP_ENCRYPT, 64'haaaaaaaaaaaaaaaa, 1'b0, 64'h0},
    '{KEYS_RESET,    OP_DECRYPT, 64'h5555555555555555, 1'b0, 64'h0},
    '{KEYS_RESET,    OP_ENCRYPT, 64'h0000000000000001, 1'b0, 64'h0},
    '{KEYS_RESET,    OP_ENCRYPT, 64'h8000000000000000, 1'b0, 64'h0},
    '{KEYS_RESET,    OP_ENCRYPT, 64'h00000000ffffffff, 1'b0, 64'h0},
    '{KEYS_RESET,    OP_DECRYPT, 64'hffffffff00000000, 1'b0, 64'h0},
    // published test vector, both directions
    '{KEYS_STANDARD, OP_ENCRYPT, 64'hfedcba9876543210, 1'b1, 64'h4ee901e5c2d8ca3d},
    '{KEYS_STANDARD, OP_DECRYPT, 64'h4ee901e5c2d8ca3d, 1'b1, 64'hfedcba9876543210},
    '{KEYS_STANDARD, OP_ENCRYPT, 64'h0000000000000000, 1'b0, 64'h0},
    // all-ones key: every key addition to a nonzero half wraps around
    '{KEYS_ONES,     OP_ENCRYPT, 64'h0000000000000000, 1'b0, 64'h0},
    '{KEYS_ONES,     OP_DECRYPT, 64'hffffffffffffffff, 1'b0, 64'h0},
    '{KEYS_ONES,     OP_ENCRYPT, 64'h0123456789abcdef, 1'b0, 64'h0},
    '{KEYS_ONES,     OP_DECRYPT, 64'h0123456789abcdef, 1'b0, 64'h0}
  };

  // Idle modes per segment: none, sender idle, receiver stalling, both.
  localparam int unsigned SEND_IDLE [4] = '{0, 84, 0, 36};
  localparam int unsigned RECV_STALL [4] = '{0, 0, 84, 36};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  key_idx_t           cfg_index = '0;
  half_t              cfg_wdata = '0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  block_t             in_tdata = '0;   // [63:0] block_in
  logic               in_tuser = 1'b0; // [0] req_type
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  block_t             out_tdata;       // [63:0] block_out

  half_t       key_shadow [KEY_WORDS];
  block_t      expected_blocks [$];
  block_t      oldest_block;
  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  magma_block_cipher DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One round: add the key word mod 2^32, substitute nibbles, rotate left by 11.
  function automatic half_t feistel_mix(input half_t half, input half_t round_key);
    half_t       sum;
    half_t       subst_out;
    logic [3:0]  nib;
    sum = half + round_key;
    subst_out = '0;
    for (int pos = 0; pos < 8; pos++) begin
      // pos counts nibbles from the top, so row pos serves nibble 7-pos
      nib = 4'((sum >> (28 - 4 * pos)) & 32'hf);
      subst_out = (subst_out << 4) | half_t'(SUBST[pos][nib]);
    end
    return (subst_out << ROT_AMT) | (subst_out >> (HALF_W - ROT_AMT));
  endfunction

  // Full 32-round transform with the key words currently loaded.
  function automatic block_t magma_cipher(input op_e op, input block_t blk);
    half_t       hi;
    half_t       lo;
    half_t       next_lo;
    int unsigned word_sel;
    hi = blk[BLOCK_W-1:HALF_W];
    lo = blk[HALF_W-1:0];
    for (int r = 0; r < ROUNDS; r++) begin
      // Encryption walks 0..7 three times then 7..0; decryption mirrors it.
      if (op == OP_DECRYPT) word_sel = (r < 8)  ? (r % 8) : (7 - r % 8);
      else                  word_sel = (r < 24) ? (r % 8) : (7 - r % 8);
      next_lo = hi ^ feistel_mix(lo, key_shadow[word_sel]);
      hi = lo;
      lo = next_lo;
    end
    // The last swap is undone: the final low half lands on top.
    return {lo, hi};
  endfunction

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic half_t key_word_for(input key_set_e keys, input int unsigned idx);
    case (keys)
      KEYS_RESET:    return '0;
      KEYS_STANDARD: return STANDARD_KEY[idx];
      KEYS_ONES:     return '1;
      default: begin
        case ($urandom_range(3))
          0:       return '0;
          1:       return '1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Favor full-random blocks, but mix in the corners of the 64-bit space.
  function automatic block_t random_block();
    block_t one_hot;
    one_hot = block_t'(1) << $urandom_range(BLOCK_W - 1);
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return one_hot;
      3:       return ~one_hot;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Write all eight key words on back-to-back cycles, then mirror them in the shadow copy.
  task automatic write_keys(input key_set_e keys);
    half_t word;
    for (int idx = 0; idx < KEY_WORDS; idx++) begin
      word = key_word_for(keys, idx);
      cfg_we    <= 1'b1;
      cfg_index <= key_idx_t'(idx);
      cfg_wdata <= word;
      @(posedge clk);
      key_shadow[idx] = word;
    end
    cfg_we <= 1'b0;
  endtask

  // Drop valid and hold until every expected block has come back.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_blocks.size() != 0) @(posedge clk);
  endtask

  // Offer one input beat after a random gap; queue its expected result on acceptance.
  task automatic send_beat(input op_e op, input block_t blk, input logic typed,
                           input block_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= blk;
    @(posedge clk);
    // values read here are the ones that stood before this edge
    while (!in_tready) @(posedge clk);
    expected_blocks.push_back(typed ? want : magma_cipher(op, blk));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall at random, compare every accepted result beat in order
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_blocks.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing outstanding", out_tdata));
      end else begin
        oldest_block = expected_blocks.pop_front();
        if (out_tdata !== oldest_block) begin
          report_mismatch($sformatf("block_out %h, predicted %h", out_tdata, oldest_block));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    key_set_e    loaded;
    key_set_e    seg_keys;
    op_e         op;
    block_t      blk;
    int unsigned sent;

    // Reset clears the key words; mirror that in the shadow copy.
    for (int idx = 0; idx < KEY_WORDS; idx++) key_shadow[idx] = '0;
    loaded = KEYS_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, no idling. The first rows run on the reset key.
    for (int row = 0; row < DIRECTED_ROWS; row++) begin
      if (DIRECTED[row].keys != loaded) begin
        wait_idle();
        write_keys(DIRECTED[row].keys);
        loaded = DIRECTED[row].keys;
      end
      send_beat(DIRECTED[row].op, DIRECTED[row].blk, DIRECTED[row].typed,
                DIRECTED[row].want);
    end

    // Random segments: a fresh key set and idle mode each, loaded only while idle.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      case (seg)
        0:       seg_keys = KEYS_RESET;
        1:       seg_keys = KEYS_ONES;
        2:       seg_keys = KEYS_STANDARD;
        default: seg_keys = KEYS_RANDOM;
      endcase
      write_keys(seg_keys);
      send_idle_pct  = SEND_IDLE[seg % 4];
      recv_stall_pct = RECV_STALL[seg % 4];
      sent = 0;
      while (sent < RANDOM_BEATS / SEGMENTS) begin
        // Now and then hold off until the pipeline is empty.
        if ($urandom_range(99) == 0) wait_idle();
        blk = random_block();
        op  = op_e'($urandom_range(1));
        if ($urandom_range(3) == 0) begin
          // Round trip: feed the predicted output back through the opposite direction.
          send_beat(op, blk, 1'b0, '0);
          send_beat(op == OP_ENCRYPT ? OP_DECRYPT : OP_ENCRYPT, magma_cipher(op, blk),
                    1'b0, '0);
          sent += 2;
        end else begin
          send_beat(op, blk, 1'b0, '0);
          sent++;
        end
      end
    end

    // Drain, let the block settle, then give the verdict.
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[magma_block_cipher] OK");
    end else begin
      $display("[magma_block_cipher] ERROR");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #WATCHDOG_TU;
    $display("timeout with %0d result beats outstanding", expected_blocks.size());
    $display("[magma_block_cipher] ERROR");
    $finish;
  end

endmodule
